@@ design/srsw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and codes of the selective-repeat send window.
// ----------------------------------------------------------------------------
package srsw_pkg;

    localparam int SEQ_W   = 32;
    localparam int TIMER_W = 16;
    localparam int EVENT_W = 3;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEW  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd2;

    localparam logic [EVENT_W-1:0] EV_SENT     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_RETX     = 3'd1;
    localparam logic [EVENT_W-1:0] EV_ACK_OK   = 3'd2;
    localparam logic [EVENT_W-1:0] EV_ACK_MISS = 3'd3;
    localparam logic [EVENT_W-1:0] EV_FULL     = 3'd4;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd1000;

    typedef struct packed {
        logic               valid;
        logic               acked;
        logic               final_m;
        logic               route;
        logic [TIMER_W-1:0] timer;
        logic [SEQ_W-1:0]   seq;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic load;
        logic set_ack;
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ design/selective_repeat_send_window_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_send_window_core
// Sender window of selective-repeat ARQ built as a row of entry cells.
//
//  channel  direction  handshake                 payload
//  in       to core    i_in_valid / o_in_stall   i_kind, i_seq_no, i_is_last
//  out      from core  o_out_valid / i_out_stall o_event_res .. o_last_of_run
//  cfg      to core    i_cfg_valid / o_cfg_ready i_cfg_data (timeout_ticks)
//
// A new packet or an unmatched acknowledgement is taken and then reported. A
// tick takes the request, rotates the whole row once through the head and then
// releases the last retransmit. A matched acknowledgement marks its entry,
// slides every acknowledged entry out of the head and then reports. Reset is
// synchronous and clears the row. A stalled output holds a tick's rotation only
// while a further retransmit is due; one further request is taken meanwhile.
// ----------------------------------------------------------------------------
module selective_repeat_send_window_core
    import srsw_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic [SEQ_W-1:0]   i_seq_no,
    input  wire logic               i_is_last,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [EVENT_W-1:0]      o_event_res,
    output logic [SEQ_W-1:0]        o_packet_seq,
    output logic                    o_route,
    output logic [3:0]              o_occupancy,
    output logic                    o_finished,
    output logic                    o_last_of_run,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [TIMER_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(WINDOW + 1);
    localparam int SW = $clog2(WINDOW);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TICK  = 3'd1;
    localparam logic [2:0] S_FLUSH = 3'd2;
    localparam logic [2:0] S_SLIDE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [SW-1:0]      r_step, n_step;
    logic               r_toggle, n_toggle;
    logic               r_done, n_done;
    logic [TIMER_W-1:0] r_timeout;

    logic               r_pend_v, n_pend_v;
    logic [EVENT_W-1:0] r_pend_ev, n_pend_ev;
    logic [SEQ_W-1:0]   r_pend_seq, n_pend_seq;
    logic               r_pend_route, n_pend_route;

    logic               r_out_v, n_out_v;
    logic [EVENT_W-1:0] r_out_ev, n_out_ev;
    logic [SEQ_W-1:0]   r_out_seq, n_out_seq;
    logic               r_out_route, n_out_route;
    logic [3:0]         r_out_occ, n_out_occ;
    logic               r_out_fin, n_out_fin;
    logic               r_out_last, n_out_last;

    t_entry             w_entry [WINDOW];
    t_entry             w_right [WINDOW];
    t_cell_ctl          w_ctl   [WINDOW];
    logic [WINDOW-1:0]  w_match;
    logic [WINDOW-1:0]  w_ack_sel;
    logic               w_hit;
    logic               w_hit_route;

    t_entry             w_new;
    t_entry             w_head_upd;
    t_entry             w_tail_in;
    logic [TIMER_W-1:0] w_load;
    logic               w_exp0;
    logic               w_accept;
    logic               w_out_free;
    logic               w_shift;
    logic               w_load_new;
    logic               w_set_ack;
    logic [CW+3:0]      w_count_ext;

    assign w_load      = (r_timeout == '0) ? TIMER_W'(1) : r_timeout;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_v || !i_out_stall;
    assign w_count_ext = {4'b0000, r_count};

    assign w_new.valid   = 1'b1;
    assign w_new.acked   = 1'b0;
    assign w_new.final_m = i_is_last;
    assign w_new.route   = r_toggle;
    assign w_new.timer   = w_load;
    assign w_new.seq     = i_seq_no;

    assign w_exp0 = w_entry[0].valid && !w_entry[0].acked &&
                    (w_entry[0].timer <= TIMER_W'(1));

    always_comb begin
        w_head_upd = w_entry[0];
        if (w_entry[0].valid && !w_entry[0].acked) begin
            if (w_exp0) begin
                w_head_upd.timer = w_load;
            end else begin
                w_head_upd.timer = w_entry[0].timer - TIMER_W'(1);
            end
        end
    end

    assign w_tail_in = (r_state == S_TICK) ? w_head_upd : t_entry'('0);

    always_comb begin
        w_hit       = 1'b0;
        w_hit_route = 1'b0;
        w_ack_sel   = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (w_match[i] && !w_hit) begin
                w_ack_sel[i] = 1'b1;
                w_hit_route  = w_entry[i].route;
                w_hit        = 1'b1;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < WINDOW; g++) begin : g_cell
            if (g == WINDOW - 1) begin : g_last
                assign w_right[g] = w_tail_in;
            end else begin : g_mid
                assign w_right[g] = w_entry[g+1];
            end
            assign w_ctl[g].shift   = w_shift;
            assign w_ctl[g].load    = w_load_new && (r_count == CW'(g));
            assign w_ctl[g].set_ack = w_set_ack && w_ack_sel[g];

            srsw_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[g]),
                .i_right (w_right[g]),
                .i_new   (w_new),
                .i_seq   (i_seq_no),
                .o_entry (w_entry[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_step       = r_step;
        n_toggle     = r_toggle;
        n_done       = r_done;
        n_pend_v     = r_pend_v;
        n_pend_ev    = r_pend_ev;
        n_pend_seq   = r_pend_seq;
        n_pend_route = r_pend_route;
        n_out_v      = r_out_v && i_out_stall;
        n_out_ev     = r_out_ev;
        n_out_seq    = r_out_seq;
        n_out_route  = r_out_route;
        n_out_occ    = r_out_occ;
        n_out_fin    = r_out_fin;
        n_out_last   = r_out_last;
        w_shift      = 1'b0;
        w_load_new   = 1'b0;
        w_set_ack    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pend_seq = i_seq_no;
                    case (i_kind)
                        KIND_TICK: begin
                            n_step   = '0;
                            n_pend_v = 1'b0;
                            n_state  = S_TICK;
                        end
                        KIND_NEW: begin
                            if (r_count < CW'(WINDOW)) begin
                                w_load_new   = 1'b1;
                                n_count      = r_count + CW'(1);
                                n_toggle     = !r_toggle;
                                n_pend_ev    = EV_SENT;
                                n_pend_route = r_toggle;
                            end else begin
                                n_pend_ev    = EV_FULL;
                                n_pend_route = 1'b0;
                            end
                            n_state = S_EMIT;
                        end
                        KIND_ACK: begin
                            if (w_hit) begin
                                w_set_ack    = 1'b1;
                                n_pend_ev    = EV_ACK_OK;
                                n_pend_route = w_hit_route;
                                n_state      = S_SLIDE;
                            end else begin
                                n_pend_ev    = EV_ACK_MISS;
                                n_pend_route = 1'b0;
                                n_state      = S_EMIT;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_TICK: begin
                if (!(w_exp0 && r_pend_v && !w_out_free)) begin
                    w_shift = 1'b1;
                    n_step  = r_step + SW'(1);
                    if (w_exp0) begin
                        if (r_pend_v) begin
                            n_out_v     = 1'b1;
                            n_out_ev    = r_pend_ev;
                            n_out_seq   = r_pend_seq;
                            n_out_route = r_pend_route;
                            n_out_occ   = w_count_ext[3:0];
                            n_out_fin   = r_done;
                            n_out_last  = 1'b0;
                        end
                        n_pend_v     = 1'b1;
                        n_pend_ev    = EV_RETX;
                        n_pend_seq   = w_entry[0].seq;
                        n_pend_route = w_entry[0].route;
                    end
                    if (r_step == SW'(WINDOW - 1)) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_v     = 1'b1;
                    n_out_ev    = r_pend_ev;
                    n_out_seq   = r_pend_seq;
                    n_out_route = r_pend_route;
                    n_out_occ   = w_count_ext[3:0];
                    n_out_fin   = r_done;
                    n_out_last  = 1'b1;
                    n_pend_v    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            S_SLIDE: begin
                if (w_entry[0].valid && w_entry[0].acked) begin
                    w_shift = 1'b1;
                    n_count = r_count - CW'(1);
                    if (w_entry[0].final_m) begin
                        n_done = 1'b1;
                    end
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_v     = 1'b1;
                    n_out_ev    = r_pend_ev;
                    n_out_seq   = r_pend_seq;
                    n_out_route = r_pend_route;
                    n_out_occ   = w_count_ext[3:0];
                    n_out_fin   = r_done;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_step    <= '0;
            r_toggle  <= 1'b0;
            r_done    <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_step   <= n_step;
            r_toggle <= n_toggle;
            r_done   <= n_done;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_ev    <= n_pend_ev;
        r_pend_seq   <= n_pend_seq;
        r_pend_route <= n_pend_route;
        r_out_ev     <= n_out_ev;
        r_out_seq    <= n_out_seq;
        r_out_route  <= n_out_route;
        r_out_occ    <= n_out_occ;
        r_out_fin    <= n_out_fin;
        r_out_last   <= n_out_last;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_v;
    assign o_event_res   = r_out_ev;
    assign o_packet_seq  = r_out_seq;
    assign o_route       = r_out_route;
    assign o_occupancy   = r_out_occ;
    assign o_finished    = r_out_fin;
    assign o_last_of_run = r_out_last;

endmodule
`default_nettype wire

@@ design/srsw_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_cell
// One window slot: holds an entry, takes its right neighbour's entry on a
// shift, loads a new packet, marks an acknowledgement and flags a match.
// ----------------------------------------------------------------------------
module srsw_cell
    import srsw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_ctl        i_ctl,
    input  wire t_entry           i_right,
    input  wire t_entry           i_new,
    input  wire logic [SEQ_W-1:0] i_seq,
    output t_entry                o_entry,
    output logic                  o_match
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_entry <= i_right;
        end else if (i_ctl.load) begin
            r_entry <= i_new;
        end else if (i_ctl.set_ack) begin
            r_entry.acked <= 1'b1;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_entry.valid && (r_entry.seq == i_seq);

endmodule
`default_nettype wire

@@ bench/tb_selective_repeat_send_window_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_send_window_core
// Self-checking bench for the selective-repeat send window. A short table of
// requests covers a fill to full, rejection, repeated and stale
// acknowledgements, the final packet and a zero timeout. Random phases
// follow, each with its own timeout. Every request is run through a
// behavioural window in the bench, and each event that the core reports is
// compared in order with the events from the table or the behavioural window.
// ----------------------------------------------------------------------------
module tb_selective_repeat_send_window_core;
    import srsw_pkg::*;

    localparam int WIN = 8;
    localparam int HALF_PERIOD = 5;
    localparam int LIMIT = 400000;
    localparam int SETTLE = 2 * WIN + 4;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 48;
    localparam int PLAN_ROWS = 21;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam logic [TIMER_W-1:0] PHASE_TIMEOUT [PHASES] =
        '{16'd1, 16'd0, 16'd2, 16'd65535, 16'd5, 16'd1000, 16'd3, 16'd1};

    typedef struct packed {
        logic [EVENT_W-1:0] ev;
        logic [SEQ_W-1:0]   pseq;
        logic               route;
        logic [3:0]         occ;
        logic               fin;
        logic               last_r;
    } t_event;

    typedef struct packed {
        logic               with_cfg;
        logic [TIMER_W-1:0] cfg_value;
        logic [KIND_W-1:0]  kind;
        logic [SEQ_W-1:0]   seq;
        logic               last;
        logic               typed;
        t_event             want;
    } t_plan_row;

    localparam t_event NO_EVENT = '0;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [KIND_W-1:0]  i_kind = KIND_TICK;
    logic [SEQ_W-1:0]   i_seq_no = '0;
    logic               i_is_last = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [EVENT_W-1:0] o_event_res;
    logic [SEQ_W-1:0]   o_packet_seq;
    logic               o_route;
    logic [3:0]         o_occupancy;
    logic               o_finished;
    logic               o_last_of_run;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [TIMER_W-1:0] i_cfg_data = '0;

    // Behavioural copy of the window.
    logic [SEQ_W-1:0]   w_seq [WIN];
    logic               w_acked [WIN];
    logic               w_closing [WIN];
    logic               w_route [WIN];
    logic [TIMER_W-1:0] w_timer [WIN];
    int                 held = 0;
    logic               route_next = 1'b0;
    logic               done_seen = 1'b0;
    logic [TIMER_W-1:0] cfg_timeout = TIMEOUT_RESET;

    t_event step_events [$];
    t_event awaited_events [$];
    int     mismatches = 0;
    int     gap_pct = 0;
    int     stall_left = 0;
    int     cycle_count = 0;

    t_plan_row plan [PLAN_ROWS] = '{
        '{1'b0, 16'd0, KIND_TICK, 32'h0, 1'b0, 1'b0, NO_EVENT},
        '{1'b0, 16'd0, KIND_SPARE, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_EVENT},
        '{1'b0, 16'd0, KIND_ACK, 32'h0, 1'b0, 1'b1,
          '{EV_ACK_MISS, 32'h0, 1'b0, 4'd0, 1'b0, 1'b1}},
        '{1'b0, 16'd0, KIND_NEW, 32'h0, 1'b0, 1'b1,
          '{EV_SENT, 32'h0, 1'b0, 4'd1, 1'b0, 1'b1}},
        '{1'b0, 16'd0, KIND_NEW, 32'hFFFF_FFFF, 1'b1, 1'b1,
          '{EV_SENT, 32'hFFFF_FFFF, 1'b1, 4'd2, 1'b0, 1'b1}},
        '{1'b0, 16'd0, KIND_NEW, 32'h5, 1'b0, 1'b1,
          '{EV_SENT, 32'h5, 1'b0, 4'd3, 1'b0, 1'b1}},
        '{1'b0, 16'd0, KIND_NEW, 32'h6, 1'b0, 1'b1,
          '{EV_SENT, 32'h6, 1'b1, 4'd4, 1'b0, 1'b1}},
        '{1'b0, 16'd0, KIND_NEW, 32'h7, 1'b0, 1'b1,
          '{EV_SENT, 32'h7, 1'b0, 4'd5, 1'b0, 1'b1}},
        '{1'b0, 16'd0, KIND_NEW, 32'h8, 1'b0, 1'b1,
          '{EV_SENT, 32'h8, 1'b1, 4'd6, 1'b0, 1'b1}},
        '{1'b0, 16'd0, KIND_NEW, 32'h9, 1'b0, 1'b1,
          '{EV_SENT, 32'h9, 1'b0, 4'd7, 1'b0, 1'b1}},
        '{1'b0, 16'd0, KIND_NEW, 32'hA, 1'b0, 1'b1,
          '{EV_SENT, 32'hA, 1'b1, 4'd8, 1'b0, 1'b1}},
        '{1'b0, 16'd0, KIND_NEW, 32'hB, 1'b1, 1'b1,
          '{EV_FULL, 32'hB, 1'b0, 4'd8, 1'b0, 1'b1}},
        '{1'b0, 16'd0, KIND_TICK, 32'h0, 1'b0, 1'b0, NO_EVENT},
        '{1'b0, 16'd0, KIND_ACK, 32'hFFFF_FFFF, 1'b0, 1'b1,
          '{EV_ACK_OK, 32'hFFFF_FFFF, 1'b1, 4'd8, 1'b0, 1'b1}},
        '{1'b0, 16'd0, KIND_ACK, 32'hFFFF_FFFF, 1'b0, 1'b1,
          '{EV_ACK_OK, 32'hFFFF_FFFF, 1'b1, 4'd8, 1'b0, 1'b1}},
        '{1'b0, 16'd0, KIND_ACK, 32'h0, 1'b0, 1'b1,
          '{EV_ACK_OK, 32'h0, 1'b0, 4'd6, 1'b1, 1'b1}},
        '{1'b0, 16'd0, KIND_ACK, 32'h0, 1'b0, 1'b1,
          '{EV_ACK_MISS, 32'h0, 1'b0, 4'd6, 1'b1, 1'b1}},
        '{1'b1, 16'd0, KIND_NEW, 32'hC, 1'b0, 1'b1,
          '{EV_SENT, 32'hC, 1'b0, 4'd7, 1'b1, 1'b1}},
        '{1'b0, 16'd0, KIND_TICK, 32'h0, 1'b0, 1'b0, NO_EVENT},
        '{1'b0, 16'd0, KIND_TICK, 32'h0, 1'b0, 1'b0, NO_EVENT},
        '{1'b1, 16'd3, KIND_ACK, 32'hC, 1'b0, 1'b1,
          '{EV_ACK_OK, 32'hC, 1'b0, 4'd7, 1'b1, 1'b1}}
    };

    selective_repeat_send_window_core #(
        .WINDOW(WIN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_seq_no      (i_seq_no),
        .i_is_last     (i_is_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_res   (o_event_res),
        .o_packet_seq  (o_packet_seq),
        .o_route       (o_route),
        .o_occupancy   (o_occupancy),
        .o_finished    (o_finished),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic logic [TIMER_W-1:0] reload_value();
        return (cfg_timeout == '0) ? TIMER_W'(1) : cfg_timeout;
    endfunction

    function automatic void note_event(input logic [EVENT_W-1:0] ev,
                                       input logic [SEQ_W-1:0] pseq,
                                       input logic route);
        step_events.push_back('{ev, pseq, route, held[3:0], done_seen, 1'b0});
    endfunction

    task automatic predict_window_events(input logic [KIND_W-1:0] kind,
                                         input logic [SEQ_W-1:0] seq,
                                         input logic last);
        int     hit;
        int     n;
        logic   rt;
        t_event tail;
        step_events.delete();
        hit = -1;
        n = 0;
        case (kind)
            KIND_TICK: begin
                for (int i = 0; i < held; i++) begin
                    if (!w_acked[i]) begin
                        if (w_timer[i] <= 1) begin
                            w_timer[i] = reload_value();
                            note_event(EV_RETX, w_seq[i], w_route[i]);
                        end else begin
                            w_timer[i] = w_timer[i] - 1'b1;
                        end
                    end
                end
            end
            KIND_NEW: begin
                if (held < WIN) begin
                    w_seq[held] = seq;
                    w_acked[held] = 1'b0;
                    w_closing[held] = last;
                    w_route[held] = route_next;
                    w_timer[held] = reload_value();
                    route_next = ~route_next;
                    held++;
                    note_event(EV_SENT, seq, w_route[held - 1]);
                end else begin
                    note_event(EV_FULL, seq, 1'b0);
                end
            end
            KIND_ACK: begin
                for (int i = 0; i < held; i++) begin
                    if (hit < 0 && w_seq[i] == seq) hit = i;
                end
                if (hit >= 0) begin
                    w_acked[hit] = 1'b1;
                    rt = w_route[hit];
                    while (n < held && w_acked[n]) begin
                        if (w_closing[n]) done_seen = 1'b1;
                        n++;
                    end
                    for (int i = 0; i + n < held; i++) begin
                        w_seq[i] = w_seq[i + n];
                        w_acked[i] = w_acked[i + n];
                        w_closing[i] = w_closing[i + n];
                        w_route[i] = w_route[i + n];
                        w_timer[i] = w_timer[i + n];
                    end
                    held -= n;
                    note_event(EV_ACK_OK, seq, rt);
                end else begin
                    note_event(EV_ACK_MISS, seq, 1'b0);
                end
            end
            default: ;
        endcase
        if (step_events.size() != 0) begin
            tail = step_events.pop_back();
            tail.last_r = 1'b1;
            step_events.push_back(tail);
        end
    endtask

    task automatic flag_mismatch(input string what, input t_event got, input t_event want);
        if (mismatches < 50) begin
            $display({"mismatch %s: got ev %0d seq %h rt %b occ %0d fin %b end %b,",
                      " want ev %0d seq %h rt %b occ %0d fin %b end %b"},
                     what, got.ev, got.pseq, got.route, got.occ, got.fin, got.last_r,
                     want.ev, want.pseq, want.route, want.occ, want.fin, want.last_r);
        end
        mismatches++;
    endtask

    task automatic offer_request(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] seq,
                                 input logic last, input logic typed, input t_event want);
        if ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_seq_no <= seq;
        i_is_last <= last;
        do @(posedge i_clk); while (o_in_stall);
        predict_window_events(kind, seq, last);
        if (typed) begin
            awaited_events.push_back(want);
        end else begin
            foreach (step_events[k]) awaited_events.push_back(step_events[k]);
        end
    endtask

    // A tick that retransmits nothing may still be rotating the row, so the
    // write waits a little beyond the last awaited event.
    task automatic write_timeout(input logic [TIMER_W-1:0] value);
        i_in_valid <= 1'b0;
        while (awaited_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_timeout = value;
    endtask

    always @(posedge i_clk) begin
        t_event got;
        t_event want;
        got = '{o_event_res, o_packet_seq, o_route, o_occupancy, o_finished, o_last_of_run};
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_events.size() == 0) begin
                flag_mismatch("unexpected", got, NO_EVENT);
            end else begin
                want = awaited_events.pop_front();
                if (got !== want) flag_mismatch("field", got, want);
            end
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
        end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct / 3) begin
            stall_left = $urandom_range(1, 6);
        end
        i_out_stall <= (stall_left != 0);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int               roll;
        int               issued;
        logic [SEQ_W-1:0] next_seq;
        logic [SEQ_W-1:0] r_seq;
        logic [KIND_W-1:0] r_kind;
        logic             r_last;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct = 20;
        foreach (plan[r]) begin
            if (plan[r].with_cfg) write_timeout(plan[r].cfg_value);
            offer_request(plan[r].kind, plan[r].seq, plan[r].last, plan[r].typed,
                          plan[r].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_timeout(PHASE_TIMEOUT[p]);
            gap_pct = (p % 3 == 2 || p == PHASES - 1) ? 0 : 30;
            next_seq = $urandom();
            issued = 0;
            while (issued < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                r_seq = $urandom();
                r_last = $urandom_range(0, 1);
                if (roll < 38) begin
                    r_kind = KIND_NEW;
                    r_last = ($urandom_range(0, 19) == 0);
                    if ($urandom_range(0, 9) != 0) begin
                        r_seq = next_seq;
                        next_seq = next_seq + 1'b1;
                    end
                end else if (roll < 70) begin
                    r_kind = KIND_ACK;
                    if (held > 0 && $urandom_range(0, 9) < 8) begin
                        r_seq = w_seq[$urandom_range(0, held - 1)];
                    end else if ($urandom_range(0, 1) == 0) begin
                        r_seq = next_seq - $urandom_range(0, 12);
                    end
                end else if (roll < 97) begin
                    r_kind = KIND_TICK;
                end else begin
                    r_kind = KIND_SPARE;
                end
                offer_request(r_kind, r_seq, r_last, 1'b0, NO_EVENT);
                if (r_kind != KIND_SPARE) issued++;
            end
        end

        i_in_valid <= 1'b0;
        while (awaited_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && awaited_events.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/srsw_pkg.sv
design/srsw_cell.sv
design/selective_repeat_send_window_core.sv
bench/tb_selective_repeat_send_window_core.sv
